// ===== hw/rtl/video_unit_cpu_register_port_defines.svh =====
// assertion macros for the video unit cpu register port
// no dependencies; included by video_unit_cpu_register_port
`ifndef VIDEO_UNIT_CPU_REGISTER_PORT_DEFINES_SVH
`define VIDEO_UNIT_CPU_REGISTER_PORT_DEFINES_SVH

// clocked check, off while reset is held
`define VUCRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define VUCRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/vucrp_pkg.sv =====
// shared types and constants of the video unit cpu register port
// no dependencies
`timescale 1ns / 1ps

package vucrp_pkg;

    // item kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // register numbers
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STAT    = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [63:0] BANK_MAP_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [5:0]  PAL_PAGE       = 6'h3F;
    localparam int          VBLANK_BIT     = 7;
    localparam int          INC32_BIT      = 2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/video_unit_cpu_register_port.sv =====
// cpu register port of the video unit: eight registers, sprite, palette and paged video memory
// the accepting edge also reads the memories; the output register takes the result as execute ends
// per item, an accept in idle for the memory read then an execute state; no new item is taken meanwhile
// execute waits while the output register holds an unaccepted result, and input stalls with it
// reset (synchronous, active low) clears registers and bank map; memories are not cleared
// depends on vucrp_pkg and video_unit_cpu_register_port_defines.svh
`timescale 1ns / 1ps

module video_unit_cpu_register_port
    import vucrp_pkg::*;
#(
    parameter int PAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_reg_select,
    input  logic [7:0]  i_data,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_control_value,
    output logic [7:0]  o_mask_value,
    output logic [7:0]  o_scroll_first,
    output logic [7:0]  o_scroll_second,
    // configuration port, bank map at every byte address with bit 3 clear
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int VADDR_W = PG_W + 10;
    localparam int VDEPTH  = PAGES * 1024;

    // control state
    t_state       r_state, n_state;
    logic [1:0]   r_kind;
    logic [2:0]   r_sel;
    logic [7:0]   r_data;
    logic [63:0]  r_bank_map;

    // architectural registers
    logic [7:0]   r_ctrl, n_ctrl;
    logic [7:0]   r_mask, n_mask;
    logic [7:0]   r_status, n_status;
    logic [7:0]   r_spr_addr, n_spr_addr;
    logic [7:0]   r_scroll0, n_scroll0;
    logic [7:0]   r_scroll1, n_scroll1;
    logic         r_toggle, n_toggle;
    logic [15:0]  r_ptr, n_ptr;
    logic [7:0]   r_rbuf, n_rbuf;

    // output register
    logic         r_out_valid;
    logic [7:0]   r_out_rd, r_out_ctrl, r_out_mask, r_out_sc0, r_out_sc1;
    logic [7:0]   n_rd;

    // memories and their registered read data
    logic [7:0]   r_spr_mem [0:255];
    logic [7:0]   r_pal_mem [0:31];
    logic [7:0]   r_vid_mem [0:VDEPTH-1];
    logic [7:0]   r_spr_q, r_pal_q, r_vid_q;

    logic         w_accept, w_done, w_cfg_wr;
    logic         w_exec, w_toggle_wr;
    logic         w_spr_we, w_pal_we, w_vid_we;
    logic         w_is_pal;
    logic [4:0]   w_pal_addr;
    logic [3:0]   w_nibble;
    logic [PG_W-1:0]    w_page;
    logic [VADDR_W-1:0] w_vid_addr;
    logic [15:0]  w_step;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_exec     = (r_state == S_EXEC);
    assign w_accept   = i_in_valid && o_in_ready;
    // finish the item once the output register is free or being drained
    assign w_done     = w_exec && (!r_out_valid || i_out_ready);
    // scroll and address writes share the toggle
    assign w_toggle_wr = w_done && (r_kind == KIND_WRITE)
                      && (r_sel == REG_SCROLL || r_sel == REG_ADDR);

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata   = paddr[3] ? 64'd0 : r_bank_map;

    // address decode, from the pointer, which only changes when an item finishes, and the bank map
    assign w_is_pal   = (r_ptr[13:8] == PAL_PAGE);
    // mirrored palette entries share one physical entry
    assign w_pal_addr = (r_ptr[1:0] == 2'b00) ? {1'b0, r_ptr[3:0]} : r_ptr[4:0];
    assign w_nibble   = r_bank_map[{r_ptr[13:10], 2'b00} +: 4];

    // page number modulo PAGES, at most three subtractions for PAGES of 4 or more
    always_comb begin
        logic [4:0] v;
        v = {1'b0, w_nibble};
        for (int k = 0; k < 4; k++) begin
            if (v >= 5'(PAGES)) begin
                v = v - 5'(PAGES);
            end
        end
        w_page = v[PG_W-1:0];
    end

    assign w_vid_addr = {w_page, r_ptr[9:0]};
    assign w_step     = r_ctrl[INC32_BIT] ? 16'd32 : 16'd1;

    // next values of the item being finished
    always_comb begin
        n_state    = r_state;
        n_ctrl     = r_ctrl;
        n_mask     = r_mask;
        n_status   = r_status;
        n_spr_addr = r_spr_addr;
        n_scroll0  = r_scroll0;
        n_scroll1  = r_scroll1;
        n_toggle   = r_toggle;
        n_ptr      = r_ptr;
        n_rbuf     = r_rbuf;
        n_rd       = 8'd0;
        w_spr_we   = 1'b0;
        w_pal_we   = 1'b0;
        w_vid_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                    unique case (r_kind)
                        KIND_READ: begin
                            unique case (r_sel)
                                REG_STAT: begin
                                    n_rd                 = r_status;
                                    n_status[VBLANK_BIT] = 1'b0;
                                end
                                REG_OAMDATA: begin
                                    n_rd       = r_spr_q;
                                    n_spr_addr = r_spr_addr + 8'd1;
                                end
                                REG_DATA: begin
                                    // palette returns at once, video data through the buffer
                                    if (w_is_pal) begin
                                        n_rd   = r_pal_q;
                                        n_rbuf = r_pal_q;
                                    end else begin
                                        n_rd   = r_rbuf;
                                        n_rbuf = r_vid_q;
                                    end
                                    n_ptr = r_ptr + w_step;
                                end
                                default: ;
                            endcase
                        end
                        KIND_WRITE: begin
                            unique case (r_sel)
                                REG_CTRL:    n_ctrl     = r_data;
                                REG_MASK:    n_mask     = r_data;
                                REG_OAMADDR: n_spr_addr = r_data;
                                REG_OAMDATA: begin
                                    w_spr_we   = 1'b1;
                                    n_spr_addr = r_spr_addr + 8'd1;
                                end
                                REG_SCROLL: begin
                                    if (r_toggle) begin
                                        n_scroll1 = r_data;
                                    end else begin
                                        n_scroll0 = r_data;
                                    end
                                    n_toggle = ~r_toggle;
                                end
                                REG_ADDR: begin
                                    // high byte first, then low byte
                                    if (r_toggle) begin
                                        n_ptr = {r_ptr[15:8], r_data};
                                    end else begin
                                        n_ptr = {r_data, r_ptr[7:0]};
                                    end
                                    n_toggle = ~r_toggle;
                                end
                                REG_DATA: begin
                                    w_pal_we = w_is_pal;
                                    w_vid_we = !w_is_pal;
                                    n_ptr    = r_ptr + w_step;
                                end
                                default: ;
                            endcase
                        end
                        KIND_STATUS: n_status = r_data;
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank_map  <= BANK_MAP_RESET;
            r_ctrl      <= 8'd0;
            r_mask      <= 8'd0;
            r_status    <= 8'd0;
            r_spr_addr  <= 8'd0;
            r_scroll0   <= 8'd0;
            r_scroll1   <= 8'd0;
            r_toggle    <= 1'b0;
            r_ptr       <= 16'd0;
            r_rbuf      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ctrl     <= n_ctrl;
            r_mask     <= n_mask;
            r_status   <= n_status;
            r_spr_addr <= n_spr_addr;
            r_scroll0  <= n_scroll0;
            r_scroll1  <= n_scroll1;
            r_toggle   <= n_toggle;
            r_ptr      <= n_ptr;
            r_rbuf     <= n_rbuf;
            if (w_cfg_wr) begin
                r_bank_map <= pwdata;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_sel  <= i_reg_select;
            r_data <= i_data;
        end
        if (w_done) begin
            r_out_rd   <= n_rd;
            r_out_ctrl <= n_ctrl;
            r_out_mask <= n_mask;
            r_out_sc0  <= n_scroll0;
            r_out_sc1  <= n_scroll1;
        end
    end

    // sprite memory
    always_ff @(posedge i_clk) begin
        if (w_spr_we) begin
            r_spr_mem[r_spr_addr] <= r_data;
        end
        if (w_accept) begin
            r_spr_q <= r_spr_mem[r_spr_addr];
        end
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (w_pal_we) begin
            r_pal_mem[w_pal_addr] <= r_data;
        end
        if (w_accept) begin
            r_pal_q <= r_pal_mem[w_pal_addr];
        end
    end

    // paged video memory
    always_ff @(posedge i_clk) begin
        if (w_vid_we) begin
            r_vid_mem[w_vid_addr] <= r_data;
        end
        if (w_accept) begin
            r_vid_q <= r_vid_mem[w_vid_addr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_rd;
    assign o_control_value = r_out_ctrl;
    assign o_mask_value    = r_out_mask;
    assign o_scroll_first  = r_out_sc0;
    assign o_scroll_second = r_out_sc1;

`include "video_unit_cpu_register_port_defines.svh"

    // an accepted item always moves to the execute cycle
    `VUCRP_ASSERT(a_accept_exec, i_clk, i_rst_n, w_accept |=> w_exec, "accept skipped execute")
    // a finished item shows up in the output register
    `VUCRP_ASSERT(a_done_out, i_clk, i_rst_n, w_done |=> o_out_valid, "result not presented")
    // scroll and address writes flip the shared toggle
    `VUCRP_ASSERT(a_toggle, i_clk, i_rst_n, w_toggle_wr |=> $changed(r_toggle), "toggle stuck")
    // reset returns the sequencer to idle with no result presented
    `VUCRP_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> o_in_ready && !o_out_valid, "not idle")

endmodule

// ===== verif/video_unit_cpu_register_port_tb.sv =====
// self-checking testbench for the video unit cpu register port
// drives cpu accesses and bank map writes, predicts every result item and checks it
// depends on vucrp_pkg and the video_unit_cpu_register_port rtl
`timescale 1ns / 1ps

module video_unit_cpu_register_port_tb;
    import vucrp_pkg::*;

    localparam int         PAGES         = 16;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [3:0] ADDR_BANK_MAP = 4'd0;
    localparam int         ITEMS_PER_RUN = 290;

    // one cpu access as the driver presents it
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] sel;
        logic [7:0] data;
    } t_cpu_access;

    // what the port shows after one access
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] control;
        logic [7:0] mask;
        logic [7:0] scroll0;
        logic [7:0] scroll1;
    } t_port_view;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_kind          = '0;
    logic [2:0]  i_reg_select    = '0;
    logic [7:0]  i_data          = '0;
    logic        i_out_ready     = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [63:0] pwdata          = '0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire  [7:0]  o_read_data;
    wire  [7:0]  o_control_value;
    wire  [7:0]  o_mask_value;
    wire  [7:0]  o_scroll_first;
    wire  [7:0]  o_scroll_second;
    wire  [63:0] prdata;
    wire         pready;

    video_unit_cpu_register_port #(
        .PAGES(PAGES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_reg_select    (i_reg_select),
        .i_data          (i_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_control_value (o_control_value),
        .o_mask_value    (o_mask_value),
        .o_scroll_first  (o_scroll_first),
        .o_scroll_second (o_scroll_second),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the port hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow of the port state, advanced once per accepted item
    // ------------------------------------------------------------------
    logic [63:0] p_bank = BANK_MAP_RESET;
    logic [7:0]  p_ctrl = '0;
    logic [7:0]  p_mask = '0;
    logic [7:0]  p_status = '0;
    logic [7:0]  p_oam_addr = '0;
    logic [7:0]  p_scroll [2] = '{8'h00, 8'h00};
    logic        p_toggle = 1'b0;
    logic [15:0] p_vaddr = '0;
    logic [7:0]  p_rdbuf = '0;
    logic [7:0]  p_oam [256];
    logic [7:0]  p_pal [32];
    logic [7:0]  p_vmem [PAGES*1024];
    // which memory entries hold a written value; reads are steered to these only
    bit          oam_seen [256];
    bit          pal_seen [32];
    bit          vmem_seen [PAGES*1024];

    t_cpu_access access_q [$];        // accesses waiting for the driver
    t_port_view  port_views [$];      // predicted port contents, oldest first
    t_cpu_access next_access;
    t_port_view  got_view;
    int          accesses_sent  = 0;
    int          accesses_taken = 0;
    int          mismatches     = 0;
    logic        calm           = 1'b0; // no idling on either side while set

    // physical byte behind a 14-bit video address, through the bank map
    function automatic int unsigned vmem_index(logic [13:0] a);
        logic [3:0] page;
        page = p_bank[a[13:10]*4 +: 4];
        return (int'(page) % PAGES) * 1024 + int'(a[9:0]);
    endfunction

    // a read is allowed only if the memory entry it touches was written
    function automatic bit read_is_safe(logic [2:0] sel);
        logic [13:0] a;
        a = p_vaddr[13:0];
        if (sel == REG_OAMDATA)
            return oam_seen[p_oam_addr];
        if (sel == REG_DATA)
            return (a[13:8] != PAL_PAGE) ? vmem_seen[vmem_index(a)] : pal_seen[a[4:0]];
        return 1'b1;
    endfunction

    function automatic void step_vaddr();
        p_vaddr = p_vaddr + (p_ctrl[INC32_BIT] ? 16'd32 : 16'd1);
    endfunction

    // applies one access to the shadow state and queues the port view it leads to
    function automatic void apply_cpu_access(logic [1:0] k, logic [2:0] sel, logic [7:0] d);
        t_port_view  v;
        logic [13:0] a;
        int unsigned idx;
        v = '0;
        a = p_vaddr[13:0];
        case (k)
            KIND_READ: begin
                case (sel)
                    REG_STAT: begin
                        v.read_data = p_status;
                        p_status[VBLANK_BIT] = 1'b0;
                    end
                    REG_OAMDATA: begin
                        v.read_data = p_oam[p_oam_addr];
                        p_oam_addr = p_oam_addr + 8'd1;
                    end
                    REG_DATA: begin
                        if (a[13:8] != PAL_PAGE) begin
                            // buffered read: old buffer out, memory byte in
                            v.read_data = p_rdbuf;
                            p_rdbuf = p_vmem[vmem_index(a)];
                        end else begin
                            v.read_data = p_pal[a[4:0]];
                            p_rdbuf = v.read_data;
                        end
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            KIND_WRITE: begin
                case (sel)
                    REG_CTRL:    p_ctrl = d;
                    REG_MASK:    p_mask = d;
                    REG_OAMADDR: p_oam_addr = d;
                    REG_OAMDATA: begin
                        p_oam[p_oam_addr] = d;
                        oam_seen[p_oam_addr] = 1'b1;
                        p_oam_addr = p_oam_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        p_scroll[p_toggle] = d;
                        p_toggle = ~p_toggle;
                    end
                    REG_ADDR: begin
                        if (p_toggle)
                            p_vaddr[7:0] = d;
                        else
                            p_vaddr[15:8] = d;
                        p_toggle = ~p_toggle;
                    end
                    REG_DATA: begin
                        if (a[13:8] != PAL_PAGE) begin
                            idx = vmem_index(a);
                            p_vmem[idx] = d;
                            vmem_seen[idx] = 1'b1;
                        end else if (a[1:0] != 2'b00) begin
                            p_pal[a[4:0]] = d;
                            pal_seen[a[4:0]] = 1'b1;
                        end else begin
                            // backdrop entries land in both palette halves
                            p_pal[{1'b0, a[3:0]}] = d;
                            p_pal[{1'b1, a[3:0]}] = d;
                            pal_seen[{1'b0, a[3:0]}] = 1'b1;
                            pal_seen[{1'b1, a[3:0]}] = 1'b1;
                        end
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            KIND_STATUS: p_status = d;
            default: ;
        endcase
        v.control = p_ctrl;
        v.mask    = p_mask;
        v.scroll0 = p_scroll[0];
        v.scroll1 = p_scroll[1];
        port_views.push_back(v);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued accesses, holds each until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            apply_cpu_access(i_kind, i_reg_select, i_data);
            accesses_taken <= accesses_taken + 1;
        end
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && access_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                next_access = access_q.pop_front();
                i_in_valid   <= 1'b1;
                i_kind       <= next_access.kind;
                i_reg_select <= next_access.sel;
                i_data       <= next_access.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end

    // ------------------------------------------------------------------
    // monitor: every result item against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("mismatch on %s: expected %02h, got %02h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (port_views.size() == 0) begin
                if (mismatches < 10)
                    $display("result item with nothing expected, read_data %02h", o_read_data);
                mismatches++;
            end else begin
                got_view = port_views.pop_front();
                check_field("read_data", got_view.read_data, o_read_data);
                check_field("control_value", got_view.control, o_control_value);
                check_field("mask_value", got_view.mask, o_mask_value);
                check_field("scroll_first", got_view.scroll0, o_scroll_first);
                check_field("scroll_second", got_view.scroll1, o_scroll_second);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // hands one access to the driver and waits until it is taken, so the
    // shadow state is current when the next access is chosen
    task automatic issue(logic [1:0] k, logic [2:0] sel, logic [7:0] d);
        t_cpu_access acc;
        // a read of a never-written entry turns into a write of the same register
        if (k == KIND_READ && !read_is_safe(sel))
            k = KIND_WRITE;
        acc.kind = k;
        acc.sel  = sel;
        acc.data = d;
        access_q.push_back(acc);
        accesses_sent++;
        wait (accesses_taken == accesses_sent);
    endtask

    // bank map write over the apb port, only with the port drained
    task automatic set_bank_map(logic [63:0] value);
        wait (access_q.size() == 0 && !i_in_valid && port_views.size() == 0);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BANK_MAP;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        p_bank = value;
    endtask

    task automatic random_scenario();
        int         pick;
        int         n;
        logic [7:0] hi;
        logic [7:0] lo;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 10);
        if (pick < 40) begin
            // video memory run: point, write a run, point again, read it back
            if (p_toggle)
                issue(KIND_WRITE, REG_SCROLL, 8'($urandom));
            if ($urandom_range(0, 1))
                issue(KIND_WRITE, REG_CTRL, 8'($urandom));
            case ($urandom_range(0, 5))
                0, 1:    hi = {2'($urandom), PAL_PAGE};
                2:       hi = 8'($urandom);
                default: hi = 8'($urandom_range(0, 8'h3E));
            endcase
            lo = 8'($urandom);
            issue(KIND_WRITE, REG_ADDR, hi);
            issue(KIND_WRITE, REG_ADDR, lo);
            repeat (n) issue(KIND_WRITE, REG_DATA, 8'($urandom));
            issue(KIND_WRITE, REG_ADDR, hi);
            issue(KIND_WRITE, REG_ADDR, lo);
            // one read past the run to pull the last byte out of the buffer
            repeat (n + 1) issue(KIND_READ, REG_DATA, 8'($urandom));
        end else if (pick < 60) begin
            // sprite run: set address, fill, set address again, read back
            lo = 8'($urandom);
            issue(KIND_WRITE, REG_OAMADDR, lo);
            repeat (n) issue(KIND_WRITE, REG_OAMDATA, 8'($urandom));
            issue(KIND_WRITE, REG_OAMADDR, lo);
            repeat (n) issue(KIND_READ, REG_OAMDATA, 8'($urandom));
        end else if (pick < 85) begin
            case ($urandom_range(0, 7))
                0: issue(KIND_WRITE, REG_CTRL, 8'($urandom));
                1: issue(KIND_WRITE, REG_MASK, 8'($urandom));
                2: issue(KIND_WRITE, REG_SCROLL, 8'($urandom));
                3: issue(KIND_STATUS, 3'($urandom), 8'($urandom));
                4: issue(KIND_READ, REG_STAT, 8'($urandom));
                5: begin
                    case ($urandom_range(0, 4))
                        0: issue(KIND_READ, REG_CTRL, 8'($urandom));
                        1: issue(KIND_READ, REG_MASK, 8'($urandom));
                        2: issue(KIND_READ, REG_OAMADDR, 8'($urandom));
                        3: issue(KIND_READ, REG_SCROLL, 8'($urandom));
                        default: issue(KIND_READ, REG_ADDR, 8'($urandom));
                    endcase
                end
                6: issue(KIND_WRITE, REG_STAT, 8'($urandom));
                default: issue(KIND_UNUSED, 3'($urandom), 8'($urandom));
            endcase
        end else begin
            // noise: anything the fields allow
            issue(2'($urandom), 3'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // status load with vblank set, then two reads: the second sees it cleared
        issue(KIND_STATUS, REG_STAT, 8'hFF);
        issue(KIND_READ, REG_STAT, 8'h00);
        issue(KIND_READ, REG_STAT, 8'h00);
        // status write is ignored
        issue(KIND_WRITE, REG_STAT, 8'h00);
        // write-only registers read back as zero
        issue(KIND_READ, REG_CTRL, 8'h00);
        issue(KIND_READ, REG_MASK, 8'h00);
        issue(KIND_READ, REG_OAMADDR, 8'h00);
        issue(KIND_READ, REG_SCROLL, 8'h00);
        issue(KIND_READ, REG_ADDR, 8'h00);
        // unused kind changes nothing
        issue(KIND_UNUSED, REG_CTRL, 8'hFF);
        // register extremes, step of 32 on
        issue(KIND_WRITE, REG_CTRL, 8'hFF);
        issue(KIND_WRITE, REG_MASK, 8'hFF);
        issue(KIND_WRITE, REG_SCROLL, 8'h00);
        issue(KIND_WRITE, REG_SCROLL, 8'hFF);
        // backdrop palette write mirrors into the upper half
        issue(KIND_WRITE, REG_ADDR, {2'b00, PAL_PAGE});
        issue(KIND_WRITE, REG_ADDR, 8'h00);
        issue(KIND_WRITE, REG_DATA, 8'hA5);
        issue(KIND_WRITE, REG_CTRL, 8'h00);
        // address bits 15:14 set, immediate palette read of the mirror
        issue(KIND_WRITE, REG_ADDR, 8'hFF);
        issue(KIND_WRITE, REG_ADDR, 8'h10);
        issue(KIND_READ, REG_DATA, 8'h00);
        // low address write, then top of the space wrapping the pointer to zero
        issue(KIND_WRITE, REG_ADDR, 8'h00);
        issue(KIND_WRITE, REG_ADDR, 8'h00);
        issue(KIND_WRITE, REG_DATA, 8'h5A);
        issue(KIND_WRITE, REG_ADDR, 8'hFF);
        issue(KIND_WRITE, REG_ADDR, 8'hFF);
        issue(KIND_WRITE, REG_DATA, 8'h00);

        // random traffic under several bank maps, reset map first and last
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       set_bank_map(64'h0);
                2:       set_bank_map('1);
                3, 4:    set_bank_map({$urandom, $urandom});
                5:       set_bank_map(BANK_MAP_RESET);
                default: ;
            endcase
            // one whole pass with both sides always willing
            calm = (ph == 2);
            while (accesses_sent < (ph + 1) * ITEMS_PER_RUN)
                random_scenario();
        end
        calm = 1'b0;

        wait (access_q.size() == 0 && !i_in_valid && port_views.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== video_unit_cpu_register_port.f =====
+incdir+hw/rtl
hw/rtl/vucrp_pkg.sv
hw/rtl/video_unit_cpu_register_port.sv
verif/video_unit_cpu_register_port_tb.sv
